[rtl/ctps_pkg.sv]
// Shared types, constants and helpers for the cosine partial-sum chain.
// No dependencies; every other file refers to this package by scoped name.
`timescale 1ns / 1ps

package ctps_pkg;

    // Series depth and fixed-point format
    localparam int MAX_ORDER = 9;
    localparam int FRAC_BITS = 29;
    localparam int NRES      = MAX_ORDER + 1;
    localparam int IDX_W     = $clog2(NRES);

    // Field widths
    localparam int ANGLE_W   = 32;
    localparam int OUT_W     = 36;
    localparam int ORD_W     = 4;

    // Datapath widths
    localparam int MAG_W     = 48;
    localparam int MAG_LO_W  = MAG_W / 2;
    localparam int MAG_HI_W  = MAG_W - MAG_LO_W;
    localparam int RECIP_W   = 32;
    localparam int SQ_W      = 2 * ANGLE_W;
    localparam int XSQ_W     = SQ_W - 1 - FRAC_BITS;
    localparam int ACC_W     = MAG_W + 6;

    localparam logic [MAG_W-1:0] TERM_CAP = '1;
    localparam logic signed [ACC_W-1:0] SUM_MAX =
        (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SUM_MIN = ~SUM_MAX;
    localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

    // round(2^32 / ((2k-1)*2k)) for k = 1..15
    localparam logic [RECIP_W-1:0] RECIP_TAB [1:15] = '{
        32'd2147483648, 32'd357913941, 32'd143165577, 32'd76695845,
        32'd47721859,   32'd32537631,  32'd23598721,  32'd17895697,
        32'd14035841,   32'd11302546,  32'd9296466,   32'd7780738,
        32'd6607642,    32'd5681174,   32'd4936744
    };

    // One angle travelling down the chain
    typedef struct packed {
        logic [XSQ_W-1:0]              xsq;
        logic [MAG_W-1:0]              mag;
        logic                          neg;
        logic signed [ACC_W-1:0]       acc;
        logic [NRES-1:0][OUT_W-1:0]    sums;
    } ctps_item_t;

    // Clamp the accumulator to the result range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
        logic [OUT_W-1:0] r;
        if (a > SUM_MAX) begin
            r = SUM_MAX[OUT_W-1:0];
        end else if (a < SUM_MIN) begin
            r = SUM_MIN[OUT_W-1:0];
        end else begin
            r = a[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/ctps_in_if.sv]
// Angle channel: valid/ready handshake with one signed angle per item.
// Depends on ctps_pkg.
`timescale 1ns / 1ps

interface ctps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ctps_pkg::ANGLE_W-1:0]  angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

[rtl/ctps_out_if.sv]
// Result channel: valid/ready handshake carrying one partial sum per item.
// Depends on ctps_pkg.
`timescale 1ns / 1ps

interface ctps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctps_pkg::OUT_W-1:0]   partial_sum;
    logic [ctps_pkg::ORD_W-1:0]          order;
    logic                                last;

    modport source (output valid, output partial_sum, output order, output last,
                    input ready);
    modport sink   (input valid, input partial_sum, input order, input last,
                    output ready);
endinterface

[rtl/ctps_square.sv]
// Head of the chain: magnitude of the angle, its square, and the order-0 term.
// Depends on ctps_pkg.
`timescale 1ns / 1ps

module ctps_square (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [ctps_pkg::ANGLE_W-1:0]        angle,
    output logic                                out_valid,
    output ctps_pkg::ctps_item_t                out_item
);

    logic                                va_reg;
    logic                                vb_reg;
    logic                                vc_reg;
    logic [ctps_pkg::ANGLE_W-1:0]        absx_reg;
    logic [ctps_pkg::ANGLE_W-1:0]        absx_next;
    logic [ctps_pkg::SQ_W-1:0]           sq_reg;
    logic [ctps_pkg::SQ_W-1:0]           sq_next;
    logic [ctps_pkg::SQ_W-1:0]           sq_round;
    ctps_pkg::ctps_item_t                item_reg;
    ctps_pkg::ctps_item_t                item_next;

    // Take the magnitude; the most negative angle maps onto itself
    assign absx_next = angle[ctps_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;

    // Square at full width
    assign sq_next = ctps_pkg::SQ_W'(absx_reg) * ctps_pkg::SQ_W'(absx_reg);

    // Round half up to the fraction width and seed the order-0 term
    always_comb
    begin
        sq_round       = sq_reg + (ctps_pkg::SQ_W'(1) << (ctps_pkg::FRAC_BITS - 1));
        item_next      = '0;
        item_next.xsq  = ctps_pkg::XSQ_W'(sq_round >> ctps_pkg::FRAC_BITS);
        item_next.mag  = ctps_pkg::ONE_MAG;
        item_next.neg  = 1'b0;
        item_next.acc  = ctps_pkg::ONE_ACC;
        item_next.sums[0] = ctps_pkg::sat_out(ctps_pkg::ONE_ACC);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            absx_reg <= absx_next;
            sq_reg   <= sq_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_item  = item_reg;

endmodule

[rtl/ctps_cell.sv]
// One cell of the chain: next term = previous term * x^2 * recip, then accumulate.
// Five stages; depends on ctps_pkg.
`timescale 1ns / 1ps

module ctps_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [ctps_pkg::RECIP_W-1:0]        recip,
    input  logic [ctps_pkg::IDX_W-1:0]          idx,
    input  logic                                in_valid,
    input  ctps_pkg::ctps_item_t                in_item,
    output logic                                out_valid,
    output ctps_pkg::ctps_item_t                out_item
);

    localparam int PA_LO_W = ctps_pkg::MAG_LO_W + ctps_pkg::XSQ_W;
    localparam int PA_HI_W = ctps_pkg::MAG_HI_W + ctps_pkg::XSQ_W;
    localparam int PA_W    = ctps_pkg::MAG_W + ctps_pkg::XSQ_W + 1;
    localparam int PB_LO_W = ctps_pkg::MAG_LO_W + ctps_pkg::RECIP_W;
    localparam int PB_HI_W = ctps_pkg::MAG_HI_W + ctps_pkg::RECIP_W;
    localparam int PB_W    = ctps_pkg::MAG_W + ctps_pkg::RECIP_W + 1;

    logic                                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    ctps_pkg::ctps_item_t                it1_reg, it2_reg, it3_reg, it4_reg, it5_reg;
    ctps_pkg::ctps_item_t                it2_next, it4_next, it5_next;
    logic [PA_LO_W-1:0]                  pa_lo_reg, pa_lo_next;
    logic [PA_HI_W-1:0]                  pa_hi_reg, pa_hi_next;
    logic [PB_LO_W-1:0]                  pb_lo_reg, pb_lo_next;
    logic [PB_HI_W-1:0]                  pb_hi_reg, pb_hi_next;
    logic [PA_W-1:0]                     pa_sum, pa_shr;
    logic [PB_W-1:0]                     pb_sum, pb_shr;
    logic signed [ctps_pkg::ACC_W-1:0]   mag_s, acc_new;

    // Stage 1: split the term magnitude, multiply by x^2
    assign pa_lo_next = PA_LO_W'(in_item.mag[ctps_pkg::MAG_LO_W-1:0])
                      * PA_LO_W'(in_item.xsq);
    assign pa_hi_next = PA_HI_W'(in_item.mag[ctps_pkg::MAG_W-1:ctps_pkg::MAG_LO_W])
                      * PA_HI_W'(in_item.xsq);

    // Stage 2: join partial products, round half up, cap
    always_comb
    begin
        pa_sum = (PA_W'(pa_hi_reg) << ctps_pkg::MAG_LO_W) + PA_W'(pa_lo_reg)
               + (PA_W'(1) << (ctps_pkg::FRAC_BITS - 1));
        pa_shr = pa_sum >> ctps_pkg::FRAC_BITS;
        it2_next = it1_reg;
        it2_next.mag = (pa_shr > PA_W'(ctps_pkg::TERM_CAP)) ? ctps_pkg::TERM_CAP
                                                          : pa_shr[ctps_pkg::MAG_W-1:0];
    end

    // Stage 3: multiply by the reciprocal of (2k-1)*2k
    assign pb_lo_next = PB_LO_W'(it2_reg.mag[ctps_pkg::MAG_LO_W-1:0]) * PB_LO_W'(recip);
    assign pb_hi_next = PB_HI_W'(it2_reg.mag[ctps_pkg::MAG_W-1:ctps_pkg::MAG_LO_W])
                      * PB_HI_W'(recip);

    // Stage 4: join, round, cap, flip the term sign
    always_comb
    begin
        pb_sum = (PB_W'(pb_hi_reg) << ctps_pkg::MAG_LO_W) + PB_W'(pb_lo_reg)
               + (PB_W'(1) << (ctps_pkg::RECIP_W - 1));
        pb_shr = pb_sum >> ctps_pkg::RECIP_W;
        it4_next = it3_reg;
        it4_next.mag = (pb_shr > PB_W'(ctps_pkg::TERM_CAP)) ? ctps_pkg::TERM_CAP
                                                          : pb_shr[ctps_pkg::MAG_W-1:0];
        it4_next.neg = ~it3_reg.neg;
    end

    // Stage 5: accumulate and record this order's clamped sum
    always_comb
    begin
        mag_s   = ctps_pkg::ACC_W'(it4_reg.mag);
        acc_new = it4_reg.neg ? (it4_reg.acc - mag_s) : (it4_reg.acc + mag_s);
        it5_next = it4_reg;
        it5_next.acc = acc_new;
        it5_next.sums[idx] = ctps_pkg::sat_out(acc_new);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg   <= in_item;
            pa_lo_reg <= pa_lo_next;
            pa_hi_reg <= pa_hi_next;
            it2_reg   <= it2_next;
            it3_reg   <= it2_reg;
            pb_lo_reg <= pb_lo_next;
            pb_hi_reg <= pb_hi_next;
            it4_reg   <= it4_next;
            it5_reg   <= it5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = it5_reg;

endmodule

[rtl/ctps_ser.sv]
// Result serializer: loads all partial sums of one angle, sends one per item.
// Depends on ctps_pkg and ctps_out_if.
`timescale 1ns / 1ps

module ctps_ser (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           tail_valid,
    input  logic [ctps_pkg::NRES-1:0][ctps_pkg::OUT_W-1:0] tail_sums,
    output logic                                           load_ready,
    ctps_out_if.source                                     res
);

    logic                                             busy_reg;
    logic [ctps_pkg::IDX_W-1:0]                       cnt_reg;
    logic [ctps_pkg::NRES-1:0][ctps_pkg::OUT_W-1:0]   hold_reg;
    logic                                             at_last;
    logic                                             load;
    logic                                             take;

    assign at_last    = (cnt_reg == ctps_pkg::IDX_W'(ctps_pkg::MAX_ORDER));
    assign take       = busy_reg && res.ready;
    assign load_ready = !busy_reg || (take && at_last);
    assign load       = tail_valid && load_ready;

    // Track the item being sent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= !at_last;
            cnt_reg  <= at_last ? cnt_reg : cnt_reg + 1'b1;
        end
    end

    // Load all sums, then shift one out per item taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= tail_sums;
        end
        else if (take)
        begin
            hold_reg <= hold_reg >> ctps_pkg::OUT_W;
        end
    end

    assign res.valid       = busy_reg;
    assign res.partial_sum = hold_reg[0];
    assign res.order       = ctps_pkg::ORD_W'(cnt_reg);
    assign res.last        = at_last;

    // A freshly loaded angle starts at order zero
    a_load_order0: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (res.valid && res.order == '0))
        else $error("loaded angle does not start at order zero");

    // Orders step by one on each item taken
    a_order_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !at_last) |=> (res.valid &&
            cnt_reg == ctps_pkg::IDX_W'($past(cnt_reg) + 1'b1)))
        else $error("order did not advance by one");

    // A stalled result keeps its order
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !res.ready) |=> (busy_reg && $stable(cnt_reg)))
        else $error("order moved while stalled");

    // Only the final order ends an angle without a new load
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (take && at_last && !tail_valid) |=> !busy_reg)
        else $error("serializer stayed busy after final order");

endmodule

[rtl/cosine_taylor_partial_sums.sv]
// Top level: cosine Maclaurin partial sums, a chain of term cells plus serializer.
// Depends on ctps_pkg, ctps_in_if, ctps_out_if, ctps_square, ctps_cell, ctps_ser.
//
//   channel | dir | item contents                          | per angle
//   --------+-----+----------------------------------------+----------
//   angles  | in  | angle, signed Q3.29                    | 1
//   sums    | out | partial_sum Q7.29, order, last         | 10
//
// An angle passes through the three-stage squaring head, then one five-stage
// cell per order, and the serializer then loads its sums. Results leave one per
// cycle while sums is ready, ten per angle, so the single result port sets the
// sustained angle rate; angles enter every cycle while the chain has room.
// Reset clears only valid bits and the serializer.
// A stall on sums freezes the whole chain once a finished angle waits; angles
// then sees ready low.
`timescale 1ns / 1ps

module cosine_taylor_partial_sums (
    input  logic           clk,
    input  logic           rst_n,
    ctps_in_if.sink        angles,
    ctps_out_if.source     sums
);

    ctps_pkg::ctps_item_t                  chain_item [0:ctps_pkg::MAX_ORDER];
    logic [ctps_pkg::MAX_ORDER:0]          chain_v;
    logic                                  adv;
    logic                                  load_ready;

    // Advance the chain unless a finished angle waits on the serializer
    assign adv          = !chain_v[ctps_pkg::MAX_ORDER] || load_ready;
    assign angles.ready = adv;

    // Square the angle and seed order zero
    ctps_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (angles.valid),
        .angle     (angles.angle),
        .out_valid (chain_v[0]),
        .out_item  (chain_item[0])
    );

    // One cell per order
    for (genvar k = 1; k <= ctps_pkg::MAX_ORDER; k++)
    begin : g_cell
        ctps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .recip     (ctps_pkg::RECIP_TAB[k]),
            .idx       (ctps_pkg::IDX_W'(k)),
            .in_valid  (chain_v[k-1]),
            .in_item   (chain_item[k-1]),
            .out_valid (chain_v[k]),
            .out_item  (chain_item[k])
        );
    end

    // Send the sums of each angle in order
    ctps_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (chain_v[ctps_pkg::MAX_ORDER]),
        .tail_sums  (chain_item[ctps_pkg::MAX_ORDER].sums),
        .load_ready (load_ready),
        .res        (sums)
    );

endmodule

[verif/cosine_taylor_partial_sums_tb.sv]
// Testbench for cosine_taylor_partial_sums: drives angles and checks every partial sum
// against a bit-exact model of the series. Depends on ctps_pkg, ctps_in_if, ctps_out_if.
`timescale 1ns / 1ps

module cosine_taylor_partial_sums_tb;

    localparam int     CLK_PERIOD   = 20;
    localparam int     DRAIN_CYCLES = 100;
    localparam longint OUT_MAX_V    = (longint'(1) << 35) - 1;

    typedef struct {
        logic signed [ctps_pkg::OUT_W-1:0] partial_sum;
        logic [ctps_pkg::ORD_W-1:0]        order;
        logic                              last;
    } cos_sum_t;

    logic clk;
    logic rst_n;

    ctps_in_if  angles_if ();
    ctps_out_if sums_if ();

    cos_sum_t expected_sums [$];
    int       mismatch_count;
    bit       gaps_on;

    cosine_taylor_partial_sums u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .angles(angles_if),
        .sums  (sums_if)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Wait cycles before the next item on either side
    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(15, 0)) : 0;
    endfunction

    // round(a*b / 2^sh), held at the 48-bit term cap
    function automatic logic [63:0] mul_round_cap(input logic [63:0] a,
                                                  input logic [63:0] b,
                                                  input int sh);
        logic [127:0] prod;
        logic [127:0] cap;
        cap  = (128'd1 << 48) - 128'd1;
        prod = {64'd0, a} * {64'd0, b};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        if (prod > cap)
            prod = cap;
        return prod[63:0];
    endfunction

    // Clamp a wide sum to the 36-bit result range
    function automatic logic signed [ctps_pkg::OUT_W-1:0] clamp_sum(input longint s);
        longint c;
        c = s;
        if (c > longint'(OUT_MAX_V))
            c = longint'(OUT_MAX_V);
        if (c < -longint'(OUT_MAX_V) - 1)
            c = -longint'(OUT_MAX_V) - 1;
        return c[ctps_pkg::OUT_W-1:0];
    endfunction

    // Work out all partial sums for one angle and queue them in order
    task automatic predict_cos_sums(input logic signed [ctps_pkg::ANGLE_W-1:0] angle);
        longint      x;
        logic [63:0] absx;
        logic [63:0] xsq;
        logic [63:0] mag;
        logic [63:0] div;
        logic [63:0] recip;
        longint      sum;
        bit          neg;
        cos_sum_t    r;
        x     = longint'(angle);
        absx  = (x < 0) ? 64'(-x) : 64'(x);
        xsq   = mul_round_cap(absx, absx, ctps_pkg::FRAC_BITS);
        mag   = 64'd1 << ctps_pkg::FRAC_BITS;
        sum   = longint'(mag);
        neg   = 1'b0;
        r.partial_sum = clamp_sum(sum);
        r.order       = '0;
        r.last        = (ctps_pkg::MAX_ORDER == 0);
        expected_sums.push_back(r);
        for (int k = 1; k <= ctps_pkg::MAX_ORDER; k++)
        begin
            div   = 64'((2 * k - 1) * (2 * k));
            recip = ((64'd1 << 32) + div / 2) / div;
            mag   = mul_round_cap(mag, xsq, ctps_pkg::FRAC_BITS);
            mag   = mul_round_cap(mag, recip, 32);
            neg   = ~neg;
            if (neg)
                sum = sum - longint'(mag);
            else
                sum = sum + longint'(mag);
            r.partial_sum = clamp_sum(sum);
            r.order       = ctps_pkg::ORD_W'(k);
            r.last        = (k == ctps_pkg::MAX_ORDER);
            expected_sums.push_back(r);
        end
    endtask

    // Offer one angle, hold it until accepted, then predict its results
    task automatic send_angle(input logic signed [ctps_pkg::ANGLE_W-1:0] angle);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            angles_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        angles_if.valid <= 1'b1;
        angles_if.angle <= angle;
        @(posedge clk);
        while (!angles_if.ready)
            @(posedge clk);
        predict_cos_sums(angle);
        @(negedge clk);
    endtask

    // Receiver: stall a random number of cycles before taking each item
    initial
    begin
        int stall;
        sums_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                sums_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            sums_if.ready <= 1'b1;
            @(posedge clk);
            while (!sums_if.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        cos_sum_t want;
        if (rst_n && sums_if.valid && sums_if.ready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("unexpected result: partial_sum %0d order %0d last %0b",
                       sums_if.partial_sum, sums_if.order, sums_if.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (sums_if.partial_sum !== want.partial_sum)
                begin
                    $error("partial_sum: expected %0d, actual %0d",
                           want.partial_sum, sums_if.partial_sum);
                    mismatch_count++;
                end
                if (sums_if.order !== want.order)
                begin
                    $error("order: expected %0d, actual %0d", want.order, sums_if.order);
                    mismatch_count++;
                end
                if (sums_if.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, sums_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Extremes, special angles and the point where terms vanish
    task automatic test_directed_angles();
        logic signed [31:0] corner [$];
        corner = '{
            32'sh0000_0000, 32'sh0000_0001, -32'sd1,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
            32'sh2000_0000, -32'sh2000_0000,              // +/-1.0
            32'sh4000_0000, -32'sh4000_0000,              // +/-2.0
            32'sd1686629713, -32'sd1686629713,            // +/-pi
            32'sd843314857,                               // pi/2
            32'sh0000_3FFF,                               // square rounds to zero
            32'sh0000_4000,                               // first term just survives
            32'sh5555_5555, 32'shAAAA_AAAA,
            32'sh6000_0000, -32'sh6000_0000               // +/-3.0
        };
        foreach (corner[i])
            send_angle(corner[i]);
    endtask

    // Random angles: full range, small, near pi and near the range ends
    task automatic test_random_angles(input int count);
        logic signed [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3, 0))
                0: a = $urandom;
                1: a = 32'($signed($urandom_range(32'h4000_0000, 0)) - 32'sh2000_0000);
                2: a = ($urandom_range(1, 0) ? 32'sd1686629713 : -32'sd1686629713)
                       + 32'($signed($urandom_range(2047, 0)) - 1024);
                default: a = $urandom_range(1, 0) ? (32'h7FFF_0000 | $urandom_range(16'hFFFF, 0))
                                                  : (32'h8000_0000 | $urandom_range(16'hFFFF, 0));
            endcase
            send_angle(a);
        end
    endtask

    // Back-to-back angles with the receiver always ready
    task automatic test_streaming_angles(input int count);
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_angle($urandom);
        gaps_on = 1'b1;
    endtask

    // Main sequence
    initial
    begin
        mismatch_count  = 0;
        gaps_on         = 1'b1;
        rst_n           = 1'b0;
        angles_if.valid = 1'b0;
        angles_if.angle = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_angles();
        test_random_angles(150);
        test_streaming_angles(40);
        test_random_angles(20);

        // Drop valid and drain the chain
        angles_if.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/ctps_pkg.sv
rtl/ctps_in_if.sv
rtl/ctps_out_if.sv
rtl/ctps_square.sv
rtl/ctps_cell.sv
rtl/ctps_ser.sv
rtl/cosine_taylor_partial_sums.sv
verif/cosine_taylor_partial_sums_tb.sv
